/* rtl/tes_pkg.sv */
// ----------------------------------------------------------------------------
// tes_pkg
// Types, codes and constants shared by the trial epoch sequencer modules.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int LOG_DEPTH = 4096;
  localparam int CNT_W     = $clog2(LOG_DEPTH) + 1;
  localparam int IDX_W     = 12;

  localparam logic [31:0] ENC_RESET = 32'hFFFF_FC19;

  localparam logic [15:0] PRE_RESET      = 16'd100;
  localparam logic [15:0] POST_RESET     = 16'd100;
  localparam logic [15:0] EPOCH_RESET    = 16'd500;
  localparam logic [7:0]  COUNT_RESET    = 8'd3;
  localparam logic [15:0] MDELAY_RESET   = 16'd100;
  localparam logic [15:0] MLENGTH_RESET  = 16'd300;
  localparam logic [15:0] INTERVAL_RESET = 16'd30;

  typedef enum logic [2:0] {
    EV_START, EV_EPOCH, EV_MOTOR_ON, EV_MOTOR_OFF, EV_FRAME, EV_STOP, EV_ENCODER
  } event_kind_t;

  typedef enum logic [2:0] {
    REG_PRE, REG_POST, REG_EPOCH_DUR, REG_EPOCH_CNT,
    REG_MOTOR_EN, REG_MOTOR_DELAY, REG_MOTOR_LEN, REG_ENC_INTERVAL
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_FRAME, ST_STOP, ST_TIME, ST_CHECK,
    ST_DIV, ST_EPOCH, ST_MOTOR, ST_ENC, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0] pre_duration;
    logic [15:0] post_duration;
    logic [15:0] epoch_duration;
    logic [7:0]  epoch_count;
    logic        motor_enable;
    logic [15:0] motor_delay;
    logic [15:0] motor_length;
    logic [15:0] encoder_interval;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic op_start;
    logic op_frame;
    logic op_stop;
    logic op_time;
    logic op_end;
    logic op_phase;
    logic op_div;
    logic op_epoch;
    logic op_mie;
    logic op_motor;
    logic op_enc;
    logic op_flush;
  } cmd_t;

  typedef struct packed {
    logic start_hit;
    logic frame_hit;
    logic stop_hit;
    logic running;
    logic over_total;
    logic epoch_go;
    logic div_last;
    logic epoch_new;
    logic motor_hit;
    logic enc_change;
    logic enc_emit;
    logic can_push;
    logic pend_valid;
  } sts_t;

  typedef struct packed {
    event_kind_t        kind;
    logic               last;
    logic               motor;
    logic               trial;
    logic               ovf;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] value;
    logic [31:0]        time_ms;
  } event_t;

endpackage

/* rtl/tes_regs.sv */
// ----------------------------------------------------------------------------
// tes_regs
// Configuration register file, written through the cfg request channel.
// ----------------------------------------------------------------------------
module tes_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [15:0]         wr_data,
  output tes_pkg::cfg_t       cfg
);
  import tes_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_duration     <= PRE_RESET;
      cfg.post_duration    <= POST_RESET;
      cfg.epoch_duration   <= EPOCH_RESET;
      cfg.epoch_count      <= COUNT_RESET;
      cfg.motor_enable     <= 1'b0;
      cfg.motor_delay      <= MDELAY_RESET;
      cfg.motor_length     <= MLENGTH_RESET;
      cfg.encoder_interval <= INTERVAL_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_PRE:          cfg.pre_duration     <= wr_data;
        REG_POST:         cfg.post_duration    <= wr_data;
        REG_EPOCH_DUR:    cfg.epoch_duration   <= wr_data;
        REG_EPOCH_CNT:    cfg.epoch_count      <= wr_data[7:0];
        REG_MOTOR_EN:     cfg.motor_enable     <= wr_data[0];
        REG_MOTOR_DELAY:  cfg.motor_delay      <= wr_data;
        REG_MOTOR_LEN:    cfg.motor_length     <= wr_data;
        REG_ENC_INTERVAL: cfg.encoder_interval <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tes_ctrl.sv */
// ----------------------------------------------------------------------------
// tes_ctrl
// Sequencer that walks one control pass through its phases.
// ----------------------------------------------------------------------------
module tes_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tes_pkg::sts_t sts,
  output tes_pkg::cmd_t cmd
);
  import tes_pkg::*;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_START;
        end
      end
      ST_START: begin
        if (!sts.start_hit) begin
          state_next = ST_FRAME;
        end else if (sts.can_push) begin
          cmd.op_start = 1'b1;
          state_next   = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (!sts.frame_hit) begin
          state_next = ST_STOP;
        end else if (sts.can_push) begin
          cmd.op_frame = 1'b1;
          state_next   = ST_STOP;
        end
      end
      ST_STOP: begin
        if (!sts.stop_hit) begin
          state_next = ST_TIME;
        end else if (sts.can_push) begin
          cmd.op_stop = 1'b1;
          state_next  = ST_TIME;
        end
      end
      ST_TIME: begin
        cmd.op_time = 1'b1;
        state_next  = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.running) begin
          state_next = ST_MOTOR;
        end else if (sts.over_total) begin
          if (sts.can_push) begin
            cmd.op_end = 1'b1;
            state_next = ST_MOTOR;
          end
        end else begin
          cmd.op_phase = 1'b1;
          state_next   = sts.epoch_go ? ST_DIV : ST_MOTOR;
        end
      end
      ST_DIV: begin
        cmd.op_div = 1'b1;
        if (sts.div_last) begin
          state_next = ST_EPOCH;
        end
      end
      ST_EPOCH: begin
        if (!sts.epoch_new) begin
          cmd.op_mie = 1'b1;
          state_next = ST_MOTOR;
        end else if (sts.can_push) begin
          cmd.op_epoch = 1'b1;
          state_next   = ST_MOTOR;
        end
      end
      ST_MOTOR: begin
        if (!sts.motor_hit) begin
          state_next = ST_ENC;
        end else if (sts.can_push) begin
          cmd.op_motor = 1'b1;
          state_next   = ST_ENC;
        end
      end
      ST_ENC: begin
        if (!sts.enc_change) begin
          state_next = ST_FLUSH;
        end else if (!sts.enc_emit || sts.can_push) begin
          cmd.op_enc = 1'b1;
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.can_push) begin
          cmd.op_flush = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/tes_dp.sv */
// ----------------------------------------------------------------------------
// tes_dp
// Trial state, epoch divider and event staging for the sequencer.
// ----------------------------------------------------------------------------
module tes_dp (
  input  logic               clk,
  input  logic               rst,
  input  tes_pkg::cfg_t      cfg,
  input  tes_pkg::cmd_t      cmd,
  output tes_pkg::sts_t      sts,
  input  logic [31:0]        now_ms,
  input  logic               start_request,
  input  logic               frame_pulse,
  input  logic               stop_request,
  input  logic signed [31:0] encoder_position,
  output tes_pkg::event_t    out_event,
  output logic               out_valid,
  input  logic               out_ready
);
  import tes_pkg::*;

  logic [31:0]        now_r;
  logic               start_r, frame_r, stop_r;
  logic signed [31:0] pos_r;

  logic               running, motor_running, in_pulse;
  logic [15:0]        trial_number, frame_count;
  logic [31:0]        trial_start, epoch_start, ms_into_trial, ms_into_epoch;
  logic [7:0]         current_epoch;
  logic [CNT_W-1:0]   event_count;
  logic [31:0]        enc_previous, enc_last_time;

  logic [23:0]        pulse_end;
  logic [23:0]        div_num;
  logic [22:0]        div_dv;
  logic [7:0]         div_q;
  logic [2:0]         div_cnt;

  event_t             pend;
  event_t             pend_last;
  logic               pend_valid;

  logic [24:0]        total;
  logic               in_pre, in_post, div_ge;
  logic [7:0]         epoch_next;
  logic [15:0]        trial_inc, frame_inc;
  logic [16:0]        motor_stop;
  logic               motor_on_hit, motor_off_hit;
  logic [31:0]        elapsed;
  logic               emit;
  event_t             ev;
  logic [CNT_W-1:0]   cnt_base, cnt_new;

  assign elapsed      = now_r - trial_start;
  assign total        = 25'(pulse_end) + 25'(cfg.post_duration);
  assign in_pre       = ms_into_trial <= 32'(cfg.pre_duration);
  assign in_post      = ms_into_trial > 32'(pulse_end);
  assign div_ge       = div_num >= 24'(div_dv);
  assign epoch_next   = div_q + 8'd1;
  assign trial_inc    = trial_number + 16'd1;
  assign frame_inc    = frame_count + 16'd1;
  assign motor_stop   = 17'(cfg.motor_delay) + 17'(cfg.motor_length);
  assign motor_on_hit = !motor_running && ms_into_epoch >= 32'(cfg.motor_delay)
                        && ms_into_epoch < 32'(motor_stop);
  assign motor_off_hit = motor_running && ms_into_epoch > 32'(motor_stop);

  always_comb begin
    sts.start_hit  = start_r && !running;
    sts.frame_hit  = frame_r && running;
    sts.stop_hit   = stop_r && running;
    sts.running    = running;
    sts.over_total = ms_into_trial > 32'(total);
    sts.epoch_go   = !in_pre && cfg.epoch_duration != 16'd0
                     && ms_into_trial < 32'(pulse_end);
    sts.div_last   = div_cnt == 3'd0;
    sts.epoch_new  = epoch_next != current_epoch;
    sts.motor_hit  = running && cfg.motor_enable && in_pulse
                     && (motor_on_hit || motor_off_hit);
    sts.enc_change = pos_r != enc_previous;
    sts.enc_emit   = !cfg.motor_enable
                     && (ms_into_trial - enc_last_time) > 32'(cfg.encoder_interval);
    sts.can_push   = !pend_valid || !out_valid;
    sts.pend_valid = pend_valid;
  end

  // event assembly
  always_comb begin
    emit       = 1'b0;
    ev         = '0;
    ev.kind    = EV_START;
    ev.trial   = running;
    ev.motor   = motor_running;
    ev.time_ms = ms_into_trial;
    cnt_base   = cmd.op_start ? '0 : event_count;
    cnt_new    = (cnt_base < CNT_W'(LOG_DEPTH)) ? cnt_base + 1'b1 : cnt_base;
    ev.index   = (cnt_new >= CNT_W'(LOG_DEPTH)) ? IDX_W'(LOG_DEPTH - 1) : IDX_W'(cnt_new);
    ev.ovf     = cnt_new >= CNT_W'(LOG_DEPTH);
    priority if (cmd.op_start) begin
      emit       = 1'b1;
      ev.time_ms = '0;
      ev.value   = 32'(trial_inc);
      ev.trial   = 1'b1;
    end else if (cmd.op_frame) begin
      emit       = 1'b1;
      ev.kind    = EV_FRAME;
      ev.time_ms = elapsed;
      ev.value   = 32'(frame_inc);
    end else if (cmd.op_stop || cmd.op_end) begin
      emit       = 1'b1;
      ev.kind    = EV_STOP;
      ev.time_ms = cmd.op_stop ? elapsed : ms_into_trial;
      ev.value   = 32'(trial_number);
      ev.trial   = 1'b0;
      ev.motor   = 1'b0;
    end else if (cmd.op_epoch) begin
      emit     = 1'b1;
      ev.kind  = EV_EPOCH;
      ev.value = 32'(epoch_next);
    end else if (cmd.op_motor) begin
      emit     = 1'b1;
      ev.kind  = motor_running ? EV_MOTOR_OFF : EV_MOTOR_ON;
      ev.value = 32'(current_epoch);
      ev.motor = !motor_running;
    end else if (cmd.op_enc) begin
      emit     = sts.enc_emit;
      ev.kind  = EV_ENCODER;
      ev.value = pos_r;
    end else begin
      emit = 1'b0;
    end
  end

  always_comb begin
    pend_last      = pend;
    pend_last.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r   <= now_ms;
      start_r <= start_request;
      frame_r <= frame_pulse;
      stop_r  <= stop_request;
      pos_r   <= encoder_position;
    end
    if (cmd.op_time) begin
      pulse_end <= 24'(cfg.pre_duration) + cfg.epoch_duration * cfg.epoch_count;
    end
    if (cmd.op_phase) begin
      div_num <= 24'(ms_into_trial - 32'(cfg.pre_duration));
      div_dv  <= {cfg.epoch_duration, 7'd0};
      div_q   <= '0;
      div_cnt <= 3'd7;
    end else if (cmd.op_div) begin
      if (div_ge) begin
        div_num <= div_num - 24'(div_dv);
      end
      div_dv  <= div_dv >> 1;
      div_q   <= {div_q[6:0], div_ge};
      div_cnt <= div_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      motor_running <= 1'b0;
      in_pulse      <= 1'b0;
      trial_number  <= '0;
      frame_count   <= '0;
      trial_start   <= '0;
      epoch_start   <= '0;
      ms_into_trial <= '0;
      ms_into_epoch <= '0;
      current_epoch <= '0;
      event_count   <= '0;
      enc_previous  <= ENC_RESET;
      enc_last_time <= ENC_RESET;
    end else begin
      if (emit) begin
        event_count <= cnt_new;
      end
      if (cmd.op_start) begin
        trial_number  <= trial_inc;
        trial_start   <= now_r;
        current_epoch <= '0;
        frame_count   <= '0;
        running       <= 1'b1;
      end
      if (cmd.op_frame) begin
        frame_count <= frame_inc;
      end
      if (cmd.op_stop || cmd.op_end) begin
        running       <= 1'b0;
        motor_running <= 1'b0;
      end
      if (cmd.op_time && running) begin
        ms_into_trial <= elapsed;
      end
      if (cmd.op_phase) begin
        in_pulse <= !in_pre && !in_post;
      end
      if (cmd.op_epoch) begin
        current_epoch <= epoch_next;
        epoch_start   <= now_r;
        ms_into_epoch <= '0;
      end
      if (cmd.op_mie) begin
        ms_into_epoch <= now_r - epoch_start;
      end
      if (cmd.op_motor) begin
        motor_running <= !motor_running;
      end
      if (cmd.op_enc) begin
        enc_previous <= pos_r;
        if (sts.enc_emit) begin
          enc_last_time <= ms_into_trial;
        end
      end
    end
  end

  // two-entry staging: pend holds the newest event until its successor or end of pass
  always_ff @(posedge clk) begin
    if (emit) begin
      pend <= ev;
    end
    if (emit && pend_valid) begin
      out_event <= pend;
    end else if (cmd.op_flush) begin
      out_event <= pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((emit && pend_valid) || cmd.op_flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.op_flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (emit && pend_valid) |-> !out_valid)
    else $error("event pushed over a full output register");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    event_count <= CNT_W'(LOG_DEPTH))
    else $error("event count beyond log depth");

  a_motor_needs_trial: assert property (@(posedge clk) disable iff (rst)
    motor_running |-> running)
    else $error("motor on without a running trial");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.op_stop || cmd.op_end) |=> (!running && !motor_running))
    else $error("stop did not clear trial and motor");

endmodule

/* rtl/trial_epoch_sequencer.sv */
// ----------------------------------------------------------------------------
// trial_epoch_sequencer
// Trial, epoch, motor and encoder event sequencer driven by control passes.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel is one control pass (time, start, frame
// and stop requests, encoder count). The pass produces zero to four events on
// m_axis, one request each; tlast marks the final event of the pass and tuser
// carries the event kind. Configuration registers are written on the cfg
// channel (index 0..7); cfg_ready is always high. The user must write them
// only while no pass is in flight; the block itself does not enforce this.
// A pass is accepted only while the sequencer is idle. The phase sequencer
// steps one phase per cycle unless a full output stalls it; an epoch number
// comes from a restoring divider producing one quotient bit per cycle.
// Events are staged one deep behind the output register, so a stalled
// receiver holds the pass in its emitting phase without losing or reordering
// events.
// Synchronous reset returns all trial state and configuration registers to
// their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module trial_epoch_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_ms[31:0], start_request[32], frame_pulse[33], stop_request[34],
  // encoder_position[66:35], zero pad[71:67]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // event_time[31:0], event_value[63:32], event_index[75:64],
  // log_overflow[76], trial_active[77], motor_active[78], zero pad[79]
  output logic [79:0] m_axis_tdata,
  // event_kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tes_pkg::*;

  cfg_t   cfg;
  cmd_t   cmd;
  sts_t   sts;
  event_t ev;

  assign cfg_ready = 1'b1;

  tes_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tes_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .now_ms           (s_axis_tdata[31:0]),
    .start_request    (s_axis_tdata[32]),
    .frame_pulse      (s_axis_tdata[33]),
    .stop_request     (s_axis_tdata[34]),
    .encoder_position (s_axis_tdata[66:35]),
    .out_event        (ev),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, ev.motor, ev.trial, ev.ovf, ev.index, ev.value, ev.time_ms};
  assign m_axis_tuser = ev.kind;
  assign m_axis_tlast = ev.last;

endmodule
